### rtl/core/wheel_speed_pid_top_assert.svh
// Assertion macros for the wheel speed PID block.
`ifndef WHEEL_SPEED_PID_TOP_ASSERT_SVH
`define WHEEL_SPEED_PID_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define WSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WSP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define WSP_ASSERT(lbl, prop, msg)
`define WSP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/core/wsp_pkg.sv
// Package for the wheel speed PID block: constants, microcode types and program.
package wsp_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Register map, word index on the configuration port.
  localparam logic [2:0] REG_GAIN_P    = 3'd0;
  localparam logic [2:0] REG_GAIN_I    = 3'd1;
  localparam logic [2:0] REG_GAIN_D    = 3'd2;
  localparam logic [2:0] REG_OUT_LOW   = 3'd3;
  localparam logic [2:0] REG_OUT_HIGH  = 3'd4;
  localparam logic [2:0] REG_TOLERANCE = 3'd5;

  localparam logic [15:0]       GAIN_P_RST    = 16'd38;
  localparam logic [15:0]       GAIN_I_RST    = 16'd51;
  localparam logic [15:0]       GAIN_D_RST    = 16'd31;
  localparam logic signed [9:0] OUT_LOW_RST   = -10'sd160;
  localparam logic [8:0]        OUT_HIGH_RST  = 9'd160;
  localparam logic [7:0]        TOLERANCE_RST = 8'd26;

  // Derivative filter weights: 0.2 as 51/256 (scaled by 256 for Q.8), 0.8 as 205/256.
  localparam logic signed [16:0] K_NEW = 17'sd13056;
  localparam logic signed [16:0] K_OLD = 17'sd205;

  localparam int STEP_W = 4;

  localparam logic [STEP_W-1:0] ST_WIN = 4'd0;
  localparam logic [STEP_W-1:0] ST_D1  = 4'd1;
  localparam logic [STEP_W-1:0] ST_D2  = 4'd2;
  localparam logic [STEP_W-1:0] ST_DF  = 4'd3;
  localparam logic [STEP_W-1:0] ST_DZ  = 4'd4;
  localparam logic [STEP_W-1:0] ST_P   = 4'd5;
  localparam logic [STEP_W-1:0] ST_I   = 4'd6;
  localparam logic [STEP_W-1:0] ST_D   = 4'd7;
  localparam logic [STEP_W-1:0] ST_OUT = 4'd8;

  typedef enum logic [2:0] {
    A_GAIN_P, A_GAIN_I, A_GAIN_D, A_K_NEW, A_K_OLD
  } a_sel_e;

  typedef enum logic [2:0] {
    B_E, B_INTEG, B_DER, B_DIFF, B_PDER
  } b_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    DER_HOLD, DER_TRUNC, DER_CLR
  } der_op_e;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_ALWAYS, JMP_ZERO
  } jmp_e;

  typedef struct packed {
    a_sel_e              a_sel;
    b_sel_e              b_sel;
    acc_op_e             acc_op;
    logic                shift8;
    logic                win_ld;
    der_op_e             der_op;
    jmp_e                jmp;
    logic [STEP_W-1:0]   jmp_to;
    logic                fin;
  } ucode_t;

  // The control program. Each item walks it once: eight steps, or seven when a zero
  // target with zero error skips the derivative filter.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{a_sel: A_GAIN_P, b_sel: B_E, acc_op: ACC_HOLD, shift8: 1'b0, win_ld: 1'b0,
          der_op: DER_HOLD, jmp: JMP_NONE, jmp_to: ST_WIN, fin: 1'b0};
    case (step)
      ST_WIN: begin
        w.win_ld = 1'b1;
      end
      ST_D1: begin
        w.a_sel  = A_K_NEW;
        w.b_sel  = B_DIFF;
        w.acc_op = ACC_LOAD;
        w.jmp    = JMP_ZERO;
        w.jmp_to = ST_DZ;
      end
      ST_D2: begin
        w.a_sel  = A_K_OLD;
        w.b_sel  = B_PDER;
        w.acc_op = ACC_ADD;
      end
      ST_DF: begin
        w.der_op = DER_TRUNC;
        w.jmp    = JMP_ALWAYS;
        w.jmp_to = ST_P;
      end
      ST_DZ: begin
        w.der_op = DER_CLR;
      end
      ST_P: begin
        w.a_sel  = A_GAIN_P;
        w.b_sel  = B_E;
        w.acc_op = ACC_LOAD;
        w.shift8 = 1'b1;
      end
      ST_I: begin
        w.a_sel  = A_GAIN_I;
        w.b_sel  = B_INTEG;
        w.acc_op = ACC_ADD;
        w.shift8 = 1'b1;
      end
      ST_D: begin
        w.a_sel  = A_GAIN_D;
        w.b_sel  = B_DER;
        w.acc_op = ACC_ADD;
      end
      ST_OUT: begin
        w.fin = 1'b1;
      end
      default: begin
        w.fin = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/wheel_speed_pid_top.sv
// Per-channel wheel speed PID controller run by a microcoded sequencer.
//
//   port group  dir  word contents (lowest bit first)
//   s_axis      in   tdata: target_speed[9:0], measured_speed[20:10]; tuser: channel[1:0]
//   m_axis      out  tdata: drive_correction[9:0]; tuser: channel_out[1:0]
//   apb         cfg  six registers at byte addresses 0, 4, ... 20
//
// Each word runs the microcode program from acceptance to its result in the output register,
// with the filter steps skipped when target and error are both zero; the shared 17x23
// multiplier and accumulator form one product at each multiply step.
// A new word is taken the cycle after the program has loaded the output register,
// so the block takes no new word until it has finished the last one.
// A stall on m_axis holds the program at its final step until the output frees.
// Reset clears configuration to its defaults and all channel state to zero.
`include "wheel_speed_pid_top_assert.svh"

module wheel_speed_pid_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // target_speed[9:0], measured_speed[20:10]
  input  logic [1:0]  s_axis_tuser,   // channel[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // drive_correction[9:0]
  output logic [1:0]  m_axis_tuser,   // channel_out[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic [15:0]       gain_p_q, gain_i_q, gain_d_q;
  logic signed [9:0] out_low_q;
  logic [8:0]        out_high_q;
  logic [7:0]        tolerance_q;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= wsp_pkg::GAIN_P_RST;
      gain_i_q    <= wsp_pkg::GAIN_I_RST;
      gain_d_q    <= wsp_pkg::GAIN_D_RST;
      out_low_q   <= wsp_pkg::OUT_LOW_RST;
      out_high_q  <= wsp_pkg::OUT_HIGH_RST;
      tolerance_q <= wsp_pkg::TOLERANCE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        wsp_pkg::REG_GAIN_P:    gain_p_q    <= pwdata[15:0];
        wsp_pkg::REG_GAIN_I:    gain_i_q    <= pwdata[15:0];
        wsp_pkg::REG_GAIN_D:    gain_d_q    <= pwdata[15:0];
        wsp_pkg::REG_OUT_LOW:   out_low_q   <= pwdata[9:0];
        wsp_pkg::REG_OUT_HIGH:  out_high_q  <= pwdata[8:0];
        wsp_pkg::REG_TOLERANCE: tolerance_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      wsp_pkg::REG_GAIN_P:    prdata = {16'd0, gain_p_q};
      wsp_pkg::REG_GAIN_I:    prdata = {16'd0, gain_i_q};
      wsp_pkg::REG_GAIN_D:    prdata = {16'd0, gain_d_q};
      wsp_pkg::REG_OUT_LOW:   prdata = {22'd0, out_low_q};
      wsp_pkg::REG_OUT_HIGH:  prdata = {23'd0, out_high_q};
      wsp_pkg::REG_TOLERANCE: prdata = {24'd0, tolerance_q};
      default:                prdata = 32'd0;
    endcase
  end

  // Channel state, one entry per wheel.
  logic signed [9:0]  integ_mem_q [wsp_pkg::CHANNELS];
  logic signed [11:0] err_mem_q   [wsp_pkg::CHANNELS];
  logic signed [21:0] der_mem_q   [wsp_pkg::CHANNELS];

  // Sequencer and datapath registers.
  logic                        busy_q, busy_d;
  logic [wsp_pkg::STEP_W-1:0]  step_q, step_d;
  wsp_pkg::ucode_t             uc;
  logic [1:0]                  ch_q;
  logic                        ch_ok_q;
  logic signed [9:0]           tgt_q;
  logic signed [11:0]          e_q, perr_q;
  logic signed [21:0]          pder_q, der_q;
  logic signed [9:0]           integ_q;
  logic                        zero_q;
  logic signed [39:0]          acc_q;
  logic                        out_vld_q;
  logic signed [9:0]           out_data_q;
  logic [1:0]                  out_ch_q;

  logic                        in_acc;
  logic [wsp_pkg::CH_IDX_W-1:0] in_idx, st_idx;
  logic                        in_ok;
  logic signed [9:0]           in_tgt;
  logic signed [10:0]          in_meas;
  logic signed [11:0]          in_err;

  logic                        out_free, fin_go, jump_go;

  assign uc            = wsp_pkg::ucode_rom(step_q);
  assign s_axis_tready = !busy_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_tgt        = s_axis_tdata[9:0];
  assign in_meas       = s_axis_tdata[20:10];
  assign in_err        = 12'(in_tgt) - 12'(in_meas);
  assign in_idx        = wsp_pkg::CH_IDX_W'(s_axis_tuser);
  assign in_ok         = 32'(s_axis_tuser) < wsp_pkg::CHANNELS;
  assign st_idx        = wsp_pkg::CH_IDX_W'(ch_q);

  assign out_free = !out_vld_q || m_axis_tready;
  assign fin_go   = busy_q && uc.fin && out_free;
  assign jump_go  = (uc.jmp == wsp_pkg::JMP_ALWAYS) || ((uc.jmp == wsp_pkg::JMP_ZERO) && zero_q);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (!busy_q) begin
      if (in_acc) begin
        busy_d = 1'b1;
        step_d = wsp_pkg::ST_WIN;
      end
    end else if (uc.fin) begin
      if (out_free) begin
        busy_d = 1'b0;
        step_d = wsp_pkg::ST_WIN;
      end
    end else if (jump_go) begin
      step_d = uc.jmp_to;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // Integration window and integral update.
  logic signed [11:0] abs_e, abs_p, mag_diff;
  logic [10:0]        gap_mag;
  logic [18:0]        gap, bound;
  logic [9:0]         abs_t;
  logic               in_win, e_nz, zero_now;
  logic signed [12:0] isum, hi13, lo13;
  logic signed [9:0]  integ_new;

  always_comb begin
    abs_e    = e_q[11] ? -e_q : e_q;
    abs_p    = perr_q[11] ? -perr_q : perr_q;
    mag_diff = abs_e - abs_p;
    gap_mag  = mag_diff[11] ? 11'(-mag_diff) : mag_diff[10:0];
    gap      = {gap_mag, 8'd0};
    abs_t    = tgt_q[9] ? 10'(-tgt_q) : tgt_q;
    bound    = 19'(tolerance_q) * 19'(abs_t);
    in_win   = gap <= bound;
    e_nz     = e_q != 12'sd0;
    zero_now = (tgt_q == 10'sd0) && !e_nz;
    isum     = 13'(integ_q) + 13'(e_q);
    hi13     = $signed({4'd0, out_high_q});
    lo13     = 13'(out_low_q);
    integ_new = integ_q;
    if (in_win && e_nz) begin
      if (isum > hi13) begin
        integ_new = 10'(out_high_q);
      end else if (isum < lo13) begin
        integ_new = out_low_q;
      end else begin
        integ_new = isum[9:0];
      end
    end else if (!in_win) begin
      integ_new = 10'sd0;
    end
    if (zero_now) begin
      integ_new = 10'sd0;
    end
  end

  // Shared multiplier and accumulator.
  logic signed [16:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [39:0] prod, prod_sh;
  logic signed [39:0] der_rnd, res_rnd;
  logic signed [23:0] res_full;
  logic signed [9:0]  res_clamp;

  always_comb begin
    case (uc.a_sel)
      wsp_pkg::A_GAIN_P: mul_a = $signed({1'b0, gain_p_q});
      wsp_pkg::A_GAIN_I: mul_a = $signed({1'b0, gain_i_q});
      wsp_pkg::A_GAIN_D: mul_a = $signed({1'b0, gain_d_q});
      wsp_pkg::A_K_NEW:  mul_a = wsp_pkg::K_NEW;
      wsp_pkg::A_K_OLD:  mul_a = wsp_pkg::K_OLD;
      default:           mul_a = 17'sd0;
    endcase
    case (uc.b_sel)
      wsp_pkg::B_E:     mul_b = 23'(e_q);
      wsp_pkg::B_INTEG: mul_b = 23'(integ_q);
      wsp_pkg::B_DER:   mul_b = 23'(der_q);
      wsp_pkg::B_DIFF:  mul_b = 23'(e_q) - 23'(perr_q);
      wsp_pkg::B_PDER:  mul_b = 23'(pder_q);
      default:          mul_b = 23'sd0;
    endcase
    prod    = mul_a * mul_b;
    prod_sh = uc.shift8 ? (prod <<< 8) : prod;
  end

  // Truncation toward zero: bias negative values before the arithmetic shift, then clamp to the output limits.
  always_comb begin
    der_rnd  = acc_q + (acc_q[39] ? 40'sd255 : 40'sd0);
    res_rnd  = acc_q + (acc_q[39] ? 40'sd65535 : 40'sd0);
    res_full = res_rnd[39:16];
    if (res_full < 24'(out_low_q)) begin
      res_clamp = out_low_q;
    end else if (res_full > $signed({15'd0, out_high_q})) begin
      res_clamp = 10'(out_high_q);
    end else begin
      res_clamp = res_full[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      step_q    <= wsp_pkg::ST_WIN;
      out_vld_q <= 1'b0;
      for (int i = 0; i < wsp_pkg::CHANNELS; i++) begin
        integ_mem_q[i] <= 10'sd0;
        err_mem_q[i]   <= 12'sd0;
        der_mem_q[i]   <= 22'sd0;
      end
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      if (fin_go) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (fin_go && ch_ok_q) begin
        integ_mem_q[st_idx] <= integ_q;
        err_mem_q[st_idx]   <= e_q;
        der_mem_q[st_idx]   <= der_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q    <= s_axis_tuser;
      ch_ok_q <= in_ok;
      tgt_q   <= in_tgt;
      e_q     <= in_err;
      perr_q  <= in_ok ? err_mem_q[in_idx] : 12'sd0;
      pder_q  <= in_ok ? der_mem_q[in_idx] : 22'sd0;
      integ_q <= in_ok ? integ_mem_q[in_idx] : 10'sd0;
    end else if (busy_q && uc.win_ld) begin
      integ_q <= integ_new;
      zero_q  <= zero_now;
    end
    case (uc.acc_op)
      wsp_pkg::ACC_LOAD: if (busy_q) acc_q <= prod_sh;
      wsp_pkg::ACC_ADD:  if (busy_q) acc_q <= acc_q + prod_sh;
      default: ;
    endcase
    case (uc.der_op)
      wsp_pkg::DER_TRUNC: if (busy_q) der_q <= der_rnd[29:8];
      wsp_pkg::DER_CLR:   if (busy_q) der_q <= 22'sd0;
      default: ;
    endcase
    if (fin_go) begin
      out_data_q <= res_clamp;
      out_ch_q   <= ch_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_data_q};
  assign m_axis_tuser  = out_ch_q;

  `WSP_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, busy_q && step_q == wsp_pkg::ST_WIN, "accepted word did not start the program")
  `WSP_ASSERT(a_step_in_program, !busy_q || step_q <= wsp_pkg::ST_OUT, "step counter left the program")
  `WSP_ASSERT_NEXT(a_stall_holds_step, busy_q && uc.fin && !out_free, busy_q && step_q == wsp_pkg::ST_OUT, "program moved while the output was blocked")

endmodule
